[hdl/sliding_window_capacity_penalty_top_defines.svh]
// Assertion macros shared by the sliding window capacity penalty RTL.
`ifndef SLIDING_WINDOW_CAPACITY_PENALTY_TOP_DEFINES_SVH
`define SLIDING_WINDOW_CAPACITY_PENALTY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SWCP_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("swcp assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SWCP_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("swcp assertion failed");
`else
`define SWCP_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define SWCP_ASSERT_NXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

[hdl/swcp_pkg.sv]
// Shared widths, register indexes and lane control type for the penalty block.
`default_nettype none
package swcp_pkg;

    localparam int MASK_W     = 8;
    localparam int ACT_W      = 4;
    localparam int CAPS_W     = 32;
    localparam int WINS_W     = 40;
    localparam int CAP_W      = 4;
    localparam int WIN_FLD_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int PEN_W      = 32;
    localparam int CARP_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS = 2'd2;

    localparam logic [ACT_W-1:0]  ACT_RESET  = 4'd8;
    localparam logic [CAPS_W-1:0] CAPS_RESET = 32'h1111_1111;
    localparam logic [WINS_W-1:0] WINS_RESET = 40'h10_8421_0842;

    localparam logic [CARP_W-1:0] CARP_MAX = 12'hFFF;

    typedef struct packed {
        logic clear;
        logic run;
        logic last;
    } lane_ctl_t;

endpackage
`default_nettype wire

[hdl/swcp_lane.sv]
// One station lane: walks the history one car a step and sums window excesses.
`default_nettype none
module swcp_lane #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                                   clk,
    input  wire swcp_pkg::lane_ctl_t                    ctl,
    input  wire logic                                   enable,
    input  wire logic [swcp_pkg::CAP_W-1:0]             cap,
    input  wire logic [swcp_pkg::WIN_FLD_W-1:0]         win,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]        avail,
    input  wire logic [$clog2(MAX_WINDOW)-1:0]          step,
    input  wire logic                                   opt_bit,
    output logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]  acc
);
    import swcp_pkg::*;

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int ACC_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int CMP_W  = (WIN_W > CAP_W) ? WIN_W : CAP_W;

    logic [WIN_W-1:0] w_eff;
    logic [WIN_W-1:0] w_m1;
    logic [WIN_W-1:0] len;
    logic [WIN_W-1:0] tail_max;
    logic [WIN_W-1:0] t_pos;
    logic [WIN_W-1:0] cnt_reg;
    logic [WIN_W-1:0] cnt_next;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CMP_W-1:0] cap_cmp;
    logic [WIN_W-1:0] exc;
    logic [WIN_W:0]   add;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    always_comb
    begin
        // window 0 acts as 1, long windows clamp to the history depth
        if (win == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (32'(win) > 32'(MAX_WINDOW))
        begin
            w_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WIN_W'(win);
        end
        w_m1     = w_eff - WIN_W'(1);
        len      = (w_eff < avail) ? w_eff : avail;
        tail_max = (w_m1 < avail) ? w_m1 : avail;
        t_pos    = WIN_W'(step) + WIN_W'(1);

        cnt_next = cnt_reg + WIN_W'(opt_bit);
        cnt_cmp  = CMP_W'(cnt_next);
        cap_cmp  = CMP_W'(cap);
        exc      = (cnt_cmp > cap_cmp) ? WIN_W'(cnt_cmp - cap_cmp) : '0;

        add = '0;
        if (t_pos == len)
        begin
            add = add + (WIN_W+1)'(exc);
        end
        if (ctl.last && (t_pos >= WIN_W'(2)) && (t_pos <= tail_max))
        begin
            add = add + (WIN_W+1)'(exc);
        end

        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.run && enable)
        begin
            acc_next = acc_reg + ACC_W'(add);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.run)
        begin
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

[hdl/swcp_merge.sv]
// Merge stage: adds the per-lane excess sums into one registered car total.
`default_nettype none
module swcp_merge #(
    parameter int LANES      = 8,
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                                                 clk,
    input  wire logic [LANES*$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]     lane_acc,
    output logic [$clog2(LANES*MAX_WINDOW*MAX_WINDOW+1)-1:0]          sum
);
    localparam int ACC_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUM_W = $clog2(LANES * MAX_WINDOW * MAX_WINDOW + 1);

    logic [SUM_W-1:0] sum_c;
    logic [SUM_W-1:0] sum_reg;

    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_c = sum_c + SUM_W'(lane_acc[i*ACC_W +: ACC_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_c;
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

[hdl/sliding_window_capacity_penalty_top.sv]
// Top level of the sliding window capacity penalty block: control, history, lanes, merge.
// Each word is scanned through the history one car a step, then merged, then delivered to the
// output register; the idle state takes the next word only once the last result is delivered,
// and output stalls hold the delivery.
// The output register lets the next input word in while a result still waits.
// Reset (rst_n low, async): control idle, history and running total zero, config to defaults.
`default_nettype none
`include "sliding_window_capacity_penalty_top_defines.svh"
module sliding_window_capacity_penalty_top #(
    parameter int STATIONS   = 8,
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [swcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [swcp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [swcp_pkg::MASK_W-1:0]       option_mask,
    input  wire logic                              last_car,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [swcp_pkg::PEN_W-1:0]             penalty_total,
    output logic [swcp_pkg::CARP_W-1:0]            car_penalty
);
    import swcp_pkg::*;

    // Stations past the mask width never see an option and add nothing,
    // so only the lower ones get a lane.
    localparam int LANES  = (STATIONS < MASK_W) ? STATIONS : MASK_W;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int STEP_W = $clog2(MAX_WINDOW);
    localparam int SEEN_W = $clog2(MAX_WINDOW);
    localparam int ACC_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUM_W  = $clog2(LANES * MAX_WINDOW * MAX_WINDOW + 1);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_WINDOW - 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX  = SEEN_W'(MAX_WINDOW - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration registers
    logic [ACT_W-1:0]  active_reg;
    logic [CAPS_W-1:0] caps_reg;
    logic [WINS_W-1:0] wins_reg;

    // sequencer
    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic              last_reg;
    logic [WIN_W-1:0]  avail_reg;
    logic [SEEN_W-1:0] seen_reg;

    // history of the most recent cars, current car at entry 0
    logic [MASK_W-1:0] hist_reg [MAX_WINDOW];

    // sequence total and output word
    logic [PEN_W-1:0]  running_reg;
    logic              out_valid_reg;
    logic [PEN_W-1:0]  total_reg;
    logic [CARP_W-1:0] carp_reg;

    logic              in_acc;
    logic              dlv;
    lane_ctl_t         lane_ctl;
    logic [LANES*ACC_W-1:0] lane_acc;
    logic [SUM_W-1:0]  merge_sum;
    logic [PEN_W:0]    total_ext;
    logic [PEN_W-1:0]  total_sat;
    logic [CARP_W-1:0] carp_sat;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    // deliver when the output register is free or being emptied this cycle
    assign dlv       = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Config writes land only while the block is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_RESET;
            caps_reg   <= CAPS_RESET;
            wins_reg   <= WINS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACTIVE:  active_reg <= cfg_data[ACT_W-1:0];
                CFG_CAPS:    caps_reg   <= cfg_data[CAPS_W-1:0];
                CFG_WINDOWS: wins_reg   <= cfg_data[WINS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (dlv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
            avail_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                // hold the word's flag and the fill level the lanes clamp against
                step_reg  <= '0;
                last_reg  <= last_car;
                avail_reg <= WIN_W'(seen_reg) + WIN_W'(1);
            end
            else if (state_reg == ST_SCAN)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (dlv)
            begin
                if (last_reg)
                begin
                    seen_reg <= '0;
                end
                else if (seen_reg < SEEN_MAX)
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
            end
        end
    end

    // Shift the new car in on accept. During the scan, rotate the line one
    // place a step so every lane reads entry 0; MAX_WINDOW steps restore it.
    // Drop the whole history after the last car of a sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (in_acc)
        begin
            hist_reg[0] <= option_mask;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        else if (state_reg == ST_SCAN)
        begin
            for (int i = 0; i < MAX_WINDOW - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[MAX_WINDOW-1] <= hist_reg[0];
        end
        else if (dlv && last_reg)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
    end

    assign lane_ctl.clear = in_acc;
    assign lane_ctl.run   = (state_reg == ST_SCAN);
    assign lane_ctl.last  = last_reg;

    for (genvar s = 0; s < LANES; s++)
    begin : g_lane
        swcp_lane #(
            .MAX_WINDOW (MAX_WINDOW)
        ) u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .enable  (32'(active_reg) > s),
            .cap     (caps_reg[s*CAP_W +: CAP_W]),
            .win     (wins_reg[s*WIN_FLD_W +: WIN_FLD_W]),
            .avail   (avail_reg),
            .step    (step_reg),
            .opt_bit (hist_reg[0][s]),
            .acc     (lane_acc[s*ACC_W +: ACC_W])
        );
    end

    swcp_merge #(
        .LANES      (LANES),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_merge (
        .clk      (clk),
        .lane_acc (lane_acc),
        .sum      (merge_sum)
    );

    // saturate the running total and the per-car figure
    always_comb
    begin
        total_ext = {1'b0, running_reg} + (PEN_W+1)'(merge_sum);
        total_sat = total_ext[PEN_W] ? '1 : total_ext[PEN_W-1:0];
        carp_sat  = (32'(merge_sum) > 32'(CARP_MAX)) ? CARP_MAX : CARP_W'(merge_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dlv)
            begin
                running_reg   <= last_reg ? '0 : total_sat;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dlv)
        begin
            total_reg <= total_sat;
            carp_reg  <= carp_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign penalty_total = total_reg;
    assign car_penalty   = carp_reg;

    // an accepted word always starts a fresh scan at step zero
    `SWCP_ASSERT_NXT(a_accept_starts_scan, clk, rst_n, in_acc,
        (state_reg == ST_SCAN) && (step_reg == '0))
    // the scan never ends early
    `SWCP_ASSERT_NXT(a_scan_runs_full, clk, rst_n,
        (state_reg == ST_SCAN) && (step_reg != LAST_STEP), state_reg == ST_SCAN)
    // a new result word only comes out of the delivery state
    `SWCP_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_DONE))

endmodule
`default_nettype wire
